// File: hdl/ecre_pkg.sv
// Shared types and constants for the extended CIGAR run encoder.
`default_nettype none
package ecre_pkg;

  localparam int FIELD_W  = 16;
  localparam int SYM_W    = 8;
  localparam int NUM_CLS  = 4;
  localparam int QDEPTH   = 4;
  localparam int QPTR_W   = $clog2(QDEPTH);
  localparam int QCNT_W   = $clog2(QDEPTH + 1);

  localparam logic [SYM_W-1:0] GAP_RESET = 8'd45;  // '-'

  typedef logic [SYM_W-1:0]   sym_t;
  typedef logic [FIELD_W-1:0] field_t;

  typedef enum logic [1:0] {
    CLS_MATCH     = 2'd0,  // '='
    CLS_MISMATCH  = 2'd1,  // 'X'
    CLS_INSERTION = 2'd2,  // 'I'
    CLS_DELETION  = 2'd3   // 'D'
  } cls_t;

  typedef struct packed {
    field_t run_length;
    cls_t   run_op;
    logic   record_end;
    field_t [NUM_CLS-1:0] totals;
    field_t [NUM_CLS-1:0] run_counts;
  } result_t;

endpackage
`default_nettype wire

// File: hdl/ecre_classify.sv
// Column classifier: sorts one aligned column into match, mismatch, insertion or deletion.
`default_nettype none
module ecre_classify (
  input  wire ecre_pkg::sym_t ref_sym,
  input  wire ecre_pkg::sym_t alt_sym,
  input  wire ecre_pkg::sym_t gap_sym,
  output ecre_pkg::cls_t      cls
);

  always_comb begin
    // gap on both sides counts as insertion
    if (ref_sym == gap_sym) begin
      cls = ecre_pkg::CLS_INSERTION;
    end else if (alt_sym == gap_sym) begin
      cls = ecre_pkg::CLS_DELETION;
    end else if (ref_sym == alt_sym) begin
      cls = ecre_pkg::CLS_MATCH;
    end else begin
      cls = ecre_pkg::CLS_MISMATCH;
    end
  end

endmodule
`default_nettype wire

// File: hdl/ecre_run_state.sv
// Run tracking and per-record totals; builds up to two result items per column.
`default_nettype none
module ecre_run_state #(
  parameter int COUNT_WIDTH = 16
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   accept,
  input  wire ecre_pkg::cls_t   cls,
  input  wire                   last,
  output ecre_pkg::result_t     res_a,
  output ecre_pkg::result_t     res_b,
  output logic                  push_a,
  output logic                  push_b
);

  localparam int NC = ecre_pkg::NUM_CLS;
  localparam int OW = ecre_pkg::FIELD_W;

  typedef logic [COUNT_WIDTH-1:0] cnt_t;

  function automatic cnt_t sat_inc(input cnt_t v);
    return (v == '1) ? v : cnt_t'(v + 1'b1);
  endfunction

  logic           run_open_r, run_open_nxt;
  ecre_pkg::cls_t cur_cls_r,  cur_cls_nxt;
  cnt_t           run_r,      run_nxt;
  cnt_t           tot_r   [NC];
  cnt_t           tot_nxt [NC];
  cnt_t           cnt_r   [NC];
  cnt_t           cnt_nxt [NC];

  logic close;
  cnt_t run_new;
  cnt_t cnt_after [NC];
  cnt_t tot_new   [NC];
  cnt_t cnt_fin   [NC];
  ecre_pkg::result_t res_close, res_final;

  assign close   = run_open_r && (cls != cur_cls_r);
  assign run_new = sat_inc(close ? '0 : run_r);

  always_comb begin
    for (int j = 0; j < NC; j++) begin
      cnt_after[j] = (close && (cur_cls_r == ecre_pkg::cls_t'(j))) ? sat_inc(cnt_r[j])
                                                                    : cnt_r[j];
      tot_new[j]   = (cls == ecre_pkg::cls_t'(j)) ? sat_inc(tot_r[j]) : tot_r[j];
      cnt_fin[j]   = (cls == ecre_pkg::cls_t'(j)) ? sat_inc(cnt_after[j]) : cnt_after[j];
    end
  end

  always_comb begin
    res_close            = '0;
    res_close.run_length = OW'(run_r);
    res_close.run_op     = cur_cls_r;
    res_close.record_end = 1'b0;

    res_final            = '0;
    res_final.run_length = OW'(run_new);
    res_final.run_op     = cls;
    res_final.record_end = 1'b1;
    for (int j = 0; j < NC; j++) begin
      res_final.totals[j]     = OW'(tot_new[j]);
      res_final.run_counts[j] = OW'(cnt_fin[j]);
    end
  end

  // slot a carries the closed run when there is one, else the final run
  assign push_a = accept && (close || last);
  assign push_b = accept && close && last;
  assign res_a  = close ? res_close : res_final;
  assign res_b  = res_final;

  always_comb begin
    run_open_nxt = run_open_r;
    cur_cls_nxt  = cur_cls_r;
    run_nxt      = run_r;
    for (int j = 0; j < NC; j++) begin
      tot_nxt[j] = tot_r[j];
      cnt_nxt[j] = cnt_r[j];
    end
    if (accept) begin
      if (last) begin
        run_open_nxt = 1'b0;
        cur_cls_nxt  = ecre_pkg::CLS_MATCH;
        run_nxt      = '0;
        for (int j = 0; j < NC; j++) begin
          tot_nxt[j] = '0;
          cnt_nxt[j] = '0;
        end
      end else begin
        run_open_nxt = 1'b1;
        cur_cls_nxt  = cls;
        run_nxt      = run_new;
        for (int j = 0; j < NC; j++) begin
          tot_nxt[j] = tot_new[j];
          cnt_nxt[j] = cnt_after[j];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_open_r <= 1'b0;
      cur_cls_r  <= ecre_pkg::CLS_MATCH;
      run_r      <= '0;
      for (int j = 0; j < NC; j++) begin
        tot_r[j] <= '0;
        cnt_r[j] <= '0;
      end
    end else begin
      run_open_r <= run_open_nxt;
      cur_cls_r  <= cur_cls_nxt;
      run_r      <= run_nxt;
      for (int j = 0; j < NC; j++) begin
        tot_r[j] <= tot_nxt[j];
        cnt_r[j] <= cnt_nxt[j];
      end
    end
  end

endmodule
`default_nettype wire

// File: hdl/ecre_out_queue.sv
// Result queue: takes up to two items a cycle, hands out one a cycle while pop_stall is low.
`default_nettype none
module ecre_out_queue (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     push_a,
  input  wire                     push_b,
  input  wire ecre_pkg::result_t  res_a,
  input  wire ecre_pkg::result_t  res_b,
  input  wire                     pop_stall,
  output logic                    head_valid,
  output ecre_pkg::result_t       head,
  output logic                    room_two
);

  localparam int PW = ecre_pkg::QPTR_W;
  localparam int CW = ecre_pkg::QCNT_W;
  localparam logic [CW-1:0] ROOM_LIMIT = CW'(ecre_pkg::QDEPTH - 2);

  ecre_pkg::result_t mem_r [ecre_pkg::QDEPTH];
  logic [PW-1:0] wr_r, wr_nxt;
  logic [PW-1:0] rd_r, rd_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          pop;
  logic [CW-1:0] push_n;

  assign head_valid = (cnt_r != '0);
  assign head       = mem_r[rd_r];
  assign room_two   = (cnt_r <= ROOM_LIMIT);
  assign pop        = head_valid && !pop_stall;
  assign push_n     = CW'(push_a) + CW'(push_b);

  always_comb begin
    wr_nxt  = PW'(wr_r + PW'(push_n));
    rd_nxt  = pop ? PW'(rd_r + 1'b1) : rd_r;
    cnt_nxt = CW'(cnt_r + push_n - CW'(pop));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_a) begin
      mem_r[wr_r] <= res_a;
    end
    if (push_b) begin
      mem_r[PW'(wr_r + 1'b1)] <= res_b;
    end
  end

endmodule
`default_nettype wire

// File: hdl/extended_cigar_run_encoder.sv
// Top level of the extended CIGAR run encoder.
// Takes one aligned column per cycle while in_stall is low and returns runs as (length,
// op) items, with the record's per-class totals and run counts on the record's final
// item. A column is classified, and the run state updated, in the cycle it is accepted;
// its results are registered in a four-entry output queue and show on out_* once they
// reach its head. in_stall rises while that queue holds more than two items, so with
// out_stall low a column goes in every cycle; a column that both changes class and ends a
// record makes two items, and a stream of those fills the queue faster than the single
// output port drains it, until in_stall holds columns back. No clearing pass after reset.
// Counters are COUNT_WIDTH bits wide and saturate; outputs show their low 16 bits.
`default_nettype none
module extended_cigar_run_encoder #(
  parameter int COUNT_WIDTH = 16
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         cfg_wr_en,
  input  wire  [7:0]  cfg_wr_data,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire  [7:0]  in_ref_symbol,
  input  wire  [7:0]  in_alt_symbol,
  input  wire         in_last_column,
  output logic        out_valid,
  input  wire         out_stall,
  output logic [15:0] out_run_length,
  output logic [1:0]  out_run_op,
  output logic        out_record_end,
  output logic [15:0] out_match_total,
  output logic [15:0] out_mismatch_total,
  output logic [15:0] out_insertion_total,
  output logic [15:0] out_deletion_total,
  output logic [15:0] out_match_run_count,
  output logic [15:0] out_mismatch_run_count,
  output logic [15:0] out_insertion_run_count,
  output logic [15:0] out_deletion_run_count
);

  ecre_pkg::sym_t    gap_r;
  ecre_pkg::cls_t    cls;
  logic              accept;
  logic              room_two;
  logic              push_a, push_b;
  ecre_pkg::result_t res_a, res_b, head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_r <= ecre_pkg::GAP_RESET;
    end else if (cfg_wr_en) begin
      gap_r <= cfg_wr_data;
    end
  end

  assign in_stall = !room_two;
  assign accept   = in_valid && room_two;

  ecre_classify u_classify (
    .ref_sym (in_ref_symbol),
    .alt_sym (in_alt_symbol),
    .gap_sym (gap_r),
    .cls     (cls)
  );

  ecre_run_state #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_run_state (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .cls    (cls),
    .last   (in_last_column),
    .res_a  (res_a),
    .res_b  (res_b),
    .push_a (push_a),
    .push_b (push_b)
  );

  ecre_out_queue u_out_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_a     (push_a),
    .push_b     (push_b),
    .res_a      (res_a),
    .res_b      (res_b),
    .pop_stall  (out_stall),
    .head_valid (out_valid),
    .head       (head),
    .room_two   (room_two)
  );

  assign out_run_length          = head.run_length;
  assign out_run_op              = head.run_op;
  assign out_record_end          = head.record_end;
  assign out_match_total         = head.totals[ecre_pkg::CLS_MATCH];
  assign out_mismatch_total      = head.totals[ecre_pkg::CLS_MISMATCH];
  assign out_insertion_total     = head.totals[ecre_pkg::CLS_INSERTION];
  assign out_deletion_total      = head.totals[ecre_pkg::CLS_DELETION];
  assign out_match_run_count     = head.run_counts[ecre_pkg::CLS_MATCH];
  assign out_mismatch_run_count  = head.run_counts[ecre_pkg::CLS_MISMATCH];
  assign out_insertion_run_count = head.run_counts[ecre_pkg::CLS_INSERTION];
  assign out_deletion_run_count  = head.run_counts[ecre_pkg::CLS_DELETION];

endmodule
`default_nettype wire

// File: hdl/ecre_checker.sv
// Port-level checks for the extended CIGAR run encoder, bound to the top level.
`default_nettype none
module ecre_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        in_valid,
  input wire        in_stall,
  input wire [7:0]  in_ref_symbol,
  input wire [7:0]  in_alt_symbol,
  input wire        in_last_column,
  input wire        out_valid,
  input wire        out_stall,
  input wire [15:0] out_run_length,
  input wire [1:0]  out_run_op,
  input wire        out_record_end,
  input wire [15:0] out_match_total,
  input wire [15:0] out_mismatch_total,
  input wire [15:0] out_insertion_total,
  input wire [15:0] out_deletion_total,
  input wire [15:0] out_match_run_count,
  input wire [15:0] out_mismatch_run_count,
  input wire [15:0] out_insertion_run_count,
  input wire [15:0] out_deletion_run_count
);

  // nothing comes out the cycle after reset
  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high right after reset");

  // a stalled item holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_run_length) &&
      $stable(out_run_op) && $stable(out_record_end))
    else $error("stalled output item changed");

  // mid-record runs carry no totals
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_record_end |->
      out_match_total == 16'd0 && out_mismatch_total == 16'd0 &&
      out_insertion_total == 16'd0 && out_deletion_total == 16'd0 &&
      out_match_run_count == 16'd0 && out_mismatch_run_count == 16'd0 &&
      out_insertion_run_count == 16'd0 && out_deletion_run_count == 16'd0)
    else $error("non-final item carries totals");

  // input side never stalls with an empty output
  assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled while output queue is empty");

  // a stalled input item holds
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_ref_symbol) &&
      $stable(in_alt_symbol) && $stable(in_last_column))
    else $error("stalled input item changed");

endmodule

bind extended_cigar_run_encoder ecre_checker u_ecre_checker (.*);
`default_nettype wire
